// ===== src/lcdsm_pkg.sv =====
package lcdsm_pkg;

  localparam int unsigned DISPLAY_POSITIONS = 11;
  localparam int unsigned MAP_COLUMNS       = 10;
  localparam int unsigned REG_BITS          = 56;
  localparam int unsigned NIB_COUNT         = 14;

  localparam logic [3:0] LAST_POS = 4'(DISPLAY_POSITIONS - 1);

  typedef enum logic [1:0] {
    MODE_REFRESH = 2'd0,
    MODE_BLINK   = 2'd1,
    MODE_OFF     = 2'd2,
    MODE_TOGGLE  = 2'd3
  } mode_e;

  typedef struct packed {
    logic [REG_BITS-1:0] lo;
    logic [REG_BITS-1:0] hi;
  } refresh_t;

  // Each entry: bit 8 selects the high register, bits 7:4 the nibble,
  // bits 3:0 the bit mask inside that nibble. A zero mask lights nothing.
  localparam logic [8:0] SEG_TABLE [0:DISPLAY_POSITIONS-1][0:MAP_COLUMNS-1] = '{
    '{9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h0B4, 9'h000, 9'h000, 9'h000},
    '{9'h052, 9'h058, 9'h048, 9'h0B8, 9'h044, 9'h051, 9'h054, 9'h098, 9'h094, 9'h000},
    '{9'h068, 9'h072, 9'h062, 9'h042, 9'h061, 9'h064, 9'h071, 9'h038, 9'h034, 9'h041},
    '{9'h0C8, 9'h0D2, 9'h0C2, 9'h032, 9'h0C1, 9'h0C4, 9'h0D1, 9'h0D8, 9'h0D4, 9'h031},
    '{9'h082, 9'h088, 9'h078, 9'h022, 9'h074, 9'h081, 9'h084, 9'h092, 9'h091, 9'h021},
    '{9'h0A8, 9'h0B2, 9'h0A2, 9'h018, 9'h0A1, 9'h0A4, 9'h0B1, 9'h028, 9'h024, 9'h014},
    '{9'h128, 9'h132, 9'h122, 9'h138, 9'h121, 9'h124, 9'h131, 9'h142, 9'h141, 9'h134},
    '{9'h152, 9'h158, 9'h148, 9'h118, 9'h144, 9'h151, 9'h154, 9'h162, 9'h161, 9'h114},
    '{9'h172, 9'h178, 9'h168, 9'h198, 9'h164, 9'h171, 9'h174, 9'h192, 9'h191, 9'h194},
    '{9'h1B8, 9'h1C2, 9'h1B2, 9'h182, 9'h1B1, 9'h1B4, 9'h1C1, 9'h188, 9'h184, 9'h181},
    '{9'h1D2, 9'h1D8, 9'h1C8, 9'h1A2, 9'h1C4, 9'h1D1, 9'h1D4, 9'h1A8, 9'h1A4, 9'h1A1}
  };

  function automatic logic [MAP_COLUMNS-1:0] seg_bits(
    input logic [3:0]          pos,
    input logic [REG_BITS-1:0] lo,
    input logic [REG_BITS-1:0] hi
  );
    logic [8:0]              ent;
    logic [REG_BITS-1:0]     src;
    logic [3:0]              nib;
    logic [MAP_COLUMNS-1:0]  bits;
    bits = '0;
    for (int s = 0; s < MAP_COLUMNS; s++) begin
      ent     = SEG_TABLE[pos][s];
      src     = ent[8] ? hi : lo;
      nib     = src[4*ent[7:4] +: 4];
      bits[s] = |(nib & ent[3:0]);
    end
    return bits;
  endfunction

endpackage

// ===== src/lcdsm_front.sv =====
module lcdsm_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [1:0]                 mode_i,
  input  logic [55:0]                low_register_nibbles_i,
  input  logic [55:0]                high_register_nibbles_i,
  input  logic [15:0]                blink_divisor_i,
  input  logic                       q_full_i,
  output logic                       full_o,
  output logic                       q_push_o,
  output lcdsm_pkg::refresh_t        q_data_o
);
  import lcdsm_pkg::*;

  logic        enabled_q, enabled_d;
  logic        blink_q, blink_d;
  logic        phase_q, phase_d;
  logic [15:0] count_q, count_d;
  logic [15:0] count_dec;
  logic        accept;
  logic        visible;
  mode_e       mode;

  assign mode      = mode_e'(mode_i);
  assign full_o    = q_full_i;
  assign accept    = push_i & ~q_full_i;
  assign visible   = enabled_q & (~blink_q | phase_q);
  assign count_dec = count_q - 16'd1;

  // The visibility decision uses the state before this item, so a blanked
  // refresh simply carries all-zero registers to the back end.
  assign q_push_o    = accept & (mode == MODE_REFRESH);
  assign q_data_o.lo = low_register_nibbles_i & {REG_BITS{visible}};
  assign q_data_o.hi = high_register_nibbles_i & {REG_BITS{visible}};

  always_comb begin
    enabled_d = enabled_q;
    blink_d   = blink_q;
    phase_d   = phase_q;
    count_d   = count_q;
    if (accept) begin
      unique case (mode)
        MODE_REFRESH: begin
          if (blink_q) begin
            if (count_dec == 16'd0) begin
              phase_d = ~phase_q;
              count_d = blink_divisor_i;
            end else begin
              count_d = count_dec;
            end
          end
        end
        MODE_BLINK: begin
          enabled_d = 1'b1;
          blink_d   = 1'b1;
          phase_d   = 1'b1;
          count_d   = blink_divisor_i;
        end
        MODE_OFF: begin
          enabled_d = 1'b0;
          blink_d   = 1'b0;
        end
        MODE_TOGGLE: begin
          enabled_d = ~enabled_q;
        end
        default: begin
          enabled_d = enabled_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b0;
      blink_q   <= 1'b0;
      phase_q   <= 1'b0;
      count_q   <= '0;
    end else begin
      enabled_q <= enabled_d;
      blink_q   <= blink_d;
      phase_q   <= phase_d;
      count_q   <= count_d;
    end
  end

endmodule

// ===== src/lcdsm_fifo.sv =====
module lcdsm_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  lcdsm_pkg::refresh_t wr_data_i,
  output logic                full_o,
  input  logic                rd_en_i,
  output lcdsm_pkg::refresh_t rd_data_o,
  output logic                empty_o
);
  import lcdsm_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);

  refresh_t            mem_q [DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q;
  logic                do_wr, do_rd;

  assign full_o    = (count_q == CntW'(DEPTH));
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_en_i & ~full_o;
  assign do_rd     = rd_en_i & ~empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== src/lcdsm_back.sv =====
module lcdsm_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  lcdsm_pkg::refresh_t q_data_i,
  output logic                q_pop_o,
  input  logic                pop_i,
  output logic                empty_o,
  output logic [3:0]          digit_position_o,
  output logic [9:0]          segment_bits_o,
  output logic                last_digit_o
);
  import lcdsm_pkg::*;

  logic                   busy_q;
  logic [3:0]             pos_q;
  refresh_t               cur_q;
  logic                   out_valid_q;
  logic [3:0]             out_pos_q;
  logic [MAP_COLUMNS-1:0] out_bits_q;
  logic                   out_last_q;
  logic                   out_free;
  logic                   emit;
  logic                   finish;

  assign out_free = ~out_valid_q | pop_i;
  assign emit     = busy_q & out_free;
  assign finish   = emit & (pos_q == LAST_POS);
  // Load the next refresh as soon as the current one hands off its last digit.
  assign q_pop_o  = (~busy_q | finish) & ~q_empty_i;

  assign empty_o          = ~out_valid_q;
  assign digit_position_o = out_pos_q;
  assign segment_bits_o   = out_bits_q;
  assign last_digit_o     = out_last_q;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_data_i;
    end
    if (emit) begin
      out_pos_q  <= pos_q;
      out_bits_q <= seg_bits(pos_q, cur_q.lo, cur_q.hi);
      out_last_q <= (pos_q == LAST_POS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
      if (q_pop_o) begin
        busy_q <= 1'b1;
        pos_q  <= '0;
      end else if (finish) begin
        busy_q <= 1'b0;
      end else if (emit) begin
        pos_q <= pos_q + 4'd1;
      end
    end
  end

endmodule

// ===== src/calculator_lcd_segment_mapper_top.sv =====
// Segment mapper for a calculator display. Each refresh transaction carries the
// two display RAM registers and produces eleven digit transactions, one per
// cycle unless pop stalls, leftmost position first; blink, off and toggle
// transactions only update the display state and produce nothing. The front end
// takes one transaction per cycle as long as the refresh queue (QUEUE_DEPTH
// entries) has room; the back end runs one table lookup per cycle unless pop
// stalls, feeding the result register, and loads the next refresh as the last
// digit leaves. A refresh passes the queue, the current-refresh register and the
// result register before its first digit shows. blink_divisor sits at address 0.
module calculator_lcd_segment_mapper_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  mode_i,
  input  logic [55:0] low_register_nibbles_i,
  input  logic [55:0] high_register_nibbles_i,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  digit_position_o,
  output logic [9:0]  segment_bits_o,
  output logic        last_digit_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lcdsm_pkg::*;

  logic [15:0] divisor_q;
  logic        cfg_wr;
  logic        q_push, q_pop, q_full, q_empty;
  refresh_t    q_wdata, q_rdata;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {16'd0, divisor_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      divisor_q <= 16'd150;
    end else if (cfg_wr) begin
      divisor_q <= pwdata[15:0];
    end
  end

  lcdsm_front u_front (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .push_i                  (push),
    .mode_i                  (mode_i),
    .low_register_nibbles_i  (low_register_nibbles_i),
    .high_register_nibbles_i (high_register_nibbles_i),
    .blink_divisor_i         (divisor_q),
    .q_full_i                (q_full),
    .full_o                  (full),
    .q_push_o                (q_push),
    .q_data_o                (q_wdata)
  );

  lcdsm_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (q_push),
    .wr_data_i (q_wdata),
    .full_o    (q_full),
    .rd_en_i   (q_pop),
    .rd_data_o (q_rdata),
    .empty_o   (q_empty)
  );

  lcdsm_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_empty_i        (q_empty),
    .q_data_i         (q_rdata),
    .q_pop_o          (q_pop),
    .pop_i            (pop),
    .empty_o          (empty),
    .digit_position_o (digit_position_o),
    .segment_bits_o   (segment_bits_o),
    .last_digit_o     (last_digit_o)
  );

endmodule

// ===== src/lcdsm_checker.sv =====
module lcdsm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [3:0] digit_position_o,
  input logic [9:0] segment_bits_o,
  input logic       last_digit_o
);
  import lcdsm_pkg::*;

  // The last-digit flag marks exactly the final position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (last_digit_o == (digit_position_o == LAST_POS)))
    else $error("last_digit does not match the final position");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (digit_position_o <= LAST_POS))
    else $error("digit position out of range");

  // Inside one refresh the digits follow each other without a gap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !last_digit_o) |=>
      (!empty && digit_position_o == $past(digit_position_o) + 4'd1))
    else $error("digit sequence broken within a refresh");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=>
      (!empty && $stable(digit_position_o) && $stable(segment_bits_o)
       && $stable(last_digit_o)))
    else $error("stalled result changed");

endmodule

bind calculator_lcd_segment_mapper_top lcdsm_checker u_lcdsm_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .empty            (empty),
  .pop              (pop),
  .digit_position_o (digit_position_o),
  .segment_bits_o   (segment_bits_o),
  .last_digit_o     (last_digit_o)
);

// ===== sim/calculator_lcd_segment_mapper_top_test.sv =====
`timescale 1ns / 1ps

module calculator_lcd_segment_mapper_top_test;
  import lcdsm_pkg::*;

  localparam logic [2:0] ADDR_BLINK_DIVISOR = 3'd0;
  localparam logic [2:0] ADDR_UNMAPPED      = 3'd4;
  localparam int unsigned SETTLE_CYCLES     = 16;
  localparam int unsigned STALL_LIMIT       = 2000;

  // Segment sources per display position: bit 8 picks the high register,
  // bits 7:4 the nibble, bits 3:0 the mask within it.
  localparam logic [8:0] SEGMENT_SOURCE [0:10][0:9] = '{
    '{9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h0B4, 9'h000, 9'h000, 9'h000},
    '{9'h052, 9'h058, 9'h048, 9'h0B8, 9'h044, 9'h051, 9'h054, 9'h098, 9'h094, 9'h000},
    '{9'h068, 9'h072, 9'h062, 9'h042, 9'h061, 9'h064, 9'h071, 9'h038, 9'h034, 9'h041},
    '{9'h0C8, 9'h0D2, 9'h0C2, 9'h032, 9'h0C1, 9'h0C4, 9'h0D1, 9'h0D8, 9'h0D4, 9'h031},
    '{9'h082, 9'h088, 9'h078, 9'h022, 9'h074, 9'h081, 9'h084, 9'h092, 9'h091, 9'h021},
    '{9'h0A8, 9'h0B2, 9'h0A2, 9'h018, 9'h0A1, 9'h0A4, 9'h0B1, 9'h028, 9'h024, 9'h014},
    '{9'h128, 9'h132, 9'h122, 9'h138, 9'h121, 9'h124, 9'h131, 9'h142, 9'h141, 9'h134},
    '{9'h152, 9'h158, 9'h148, 9'h118, 9'h144, 9'h151, 9'h154, 9'h162, 9'h161, 9'h114},
    '{9'h172, 9'h178, 9'h168, 9'h198, 9'h164, 9'h171, 9'h174, 9'h192, 9'h191, 9'h194},
    '{9'h1B8, 9'h1C2, 9'h1B2, 9'h182, 9'h1B1, 9'h1B4, 9'h1C1, 9'h188, 9'h184, 9'h181},
    '{9'h1D2, 9'h1D8, 9'h1C8, 9'h1A2, 9'h1C4, 9'h1D1, 9'h1D4, 9'h1A8, 9'h1A4, 9'h1A1}
  };

  typedef struct packed {
    logic [3:0] pos;
    logic [9:0] segs;
    logic       last;
  } digit_t;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [1:0]  mode_i;
  logic [55:0] low_register_nibbles_i;
  logic [55:0] high_register_nibbles_i;
  logic        empty;
  logic        pop = 1'b0;
  logic [3:0]  digit_position_o;
  logic [9:0]  segment_bits_o;
  logic        last_digit_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Predicted display state and the digits still owed by the block.
  logic        disp_on;
  logic        blink_on;
  logic        phase_on;
  logic [15:0] countdown;
  logic [15:0] divisor;
  digit_t      expected_digits[$];

  int fail_count;
  int refresh_count;
  int op_count;
  int digits_checked;
  int lit_digits;
  int phase_flips;
  int burst_left;
  bit push_held;

  calculator_lcd_segment_mapper_top u_dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .push                   (push),
    .full                   (full),
    .mode_i                 (mode_i),
    .low_register_nibbles_i (low_register_nibbles_i),
    .high_register_nibbles_i(high_register_nibbles_i),
    .empty                  (empty),
    .pop                    (pop),
    .digit_position_o       (digit_position_o),
    .segment_bits_o         (segment_bits_o),
    .last_digit_o           (last_digit_o),
    .psel                   (psel),
    .penable                (penable),
    .pwrite                 (pwrite),
    .paddr                  (paddr),
    .pwdata                 (pwdata),
    .prdata                 (prdata),
    .pready                 (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [9:0] lit_segments(input int unsigned pos, input logic [55:0] lo,
                                               input logic [55:0] hi);
    logic [8:0]  src;
    logic [55:0] word;
    logic [3:0]  nib;
    logic [9:0]  segs;
    segs = '0;
    for (int s = 0; s < 10; s++) begin
      src     = SEGMENT_SOURCE[pos][s];
      word    = src[8] ? hi : lo;
      nib     = 4'(word >> (4 * src[7:4]));
      segs[s] = (src[3:0] != 4'h0) && ((nib & src[3:0]) != 4'h0);
    end
    return segs;
  endfunction

  task automatic predict_digits(input mode_e m, input logic [55:0] lo, input logic [55:0] hi);
    logic   visible;
    digit_t d;
    case (m)
      MODE_BLINK: begin
        disp_on   = 1'b1;
        blink_on  = 1'b1;
        phase_on  = 1'b1;
        countdown = divisor;
        op_count++;
      end
      MODE_OFF: begin
        disp_on  = 1'b0;
        blink_on = 1'b0;
        op_count++;
      end
      MODE_TOGGLE: begin
        disp_on = ~disp_on;
        op_count++;
      end
      default: begin
        visible = disp_on && (!blink_on || phase_on);
        for (int p = 0; p < DISPLAY_POSITIONS; p++) begin
          d.pos  = 4'(p);
          d.segs = visible ? lit_segments(p, lo, hi) : 10'h000;
          d.last = (p == DISPLAY_POSITIONS - 1);
          expected_digits.push_back(d);
        end
        // The counter moves after the digits are formed from the old state.
        if (blink_on) begin
          countdown = countdown - 16'd1;
          if (countdown == 16'd0) begin
            phase_on  = ~phase_on;
            countdown = divisor;
            phase_flips++;
          end
        end
        refresh_count++;
      end
    endcase
  endtask

  task automatic send_item(input mode_e m, input logic [55:0] lo, input logic [55:0] hi);
    push                    <= 1'b1;
    mode_i                  <= m;
    low_register_nibbles_i  <= lo;
    high_register_nibbles_i <= hi;
    do @(posedge clk_i); while (full);
    predict_digits(m, lo, hi);
    if (burst_left > 0) begin
      burst_left--;
      push_held = 1'b1;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
      push      <= 1'b0;
      push_held  = 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  // Lets the block drain: releases push, waits until all expected digits are
  // delivered, then waits a further settling time.
  task automatic wait_idle();
    if (push_held) begin
      push     <= 1'b0;
      push_held = 1'b0;
    end
    while (expected_digits.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_access(input bit wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_divisor_readback();
    logic [31:0] rdata;
    apb_access(1'b0, ADDR_BLINK_DIVISOR, 32'h0, rdata);
    if (rdata !== {16'h0, divisor}) begin
      $display("%0t: blink_divisor readback: expected %08h, actual %08h", $time,
               {16'h0, divisor}, rdata);
      fail_count++;
    end
  endtask

  task automatic write_divisor(input logic [31:0] wdata);
    logic [31:0] rdata;
    apb_access(1'b1, ADDR_BLINK_DIVISOR, wdata, rdata);
    divisor = wdata[15:0];
    check_divisor_readback();
  endtask

  function automatic logic [55:0] random_register();
    logic [55:0] r;
    r = 56'({$urandom, $urandom});
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return 56'(1) << $urandom_range(0, 55);
      3:       return r & 56'({$urandom, $urandom}) & 56'({$urandom, $urandom});
      default: return r;
    endcase
  endfunction

  // Receiver: pop follows one of four stall styles, picked anew at random whenever the current stretch runs out.
  int unsigned cycle_count;
  int unsigned stall_style;
  int unsigned stall_len;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (stall_len == 0) begin
      stall_style <= $urandom_range(0, 3);
      stall_len   <= $urandom_range(20, 80);
    end else begin
      stall_len <= stall_len - 1;
    end
    case (stall_style)
      0:       pop <= 1'b1;
      1:       pop <= ($urandom_range(0, 2) != 0);
      2:       pop <= (cycle_count % 7 < 3);
      default: pop <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    digit_t want;
    if (rst_ni && pop && !empty) begin
      if (expected_digits.size() == 0) begin
        $display("%0t: unexpected digit: expected none, actual pos %0d segs %03h last %0b",
                 $time, digit_position_o, segment_bits_o, last_digit_o);
        fail_count++;
      end else begin
        want = expected_digits.pop_front();
        digits_checked++;
        if (want.segs != 10'h000) lit_digits++;
        if (digit_position_o !== want.pos || segment_bits_o !== want.segs ||
            last_digit_o !== want.last) begin
          $display("%0t: digit mismatch: expected pos %0d segs %03h last %0b, actual pos %0d segs %03h last %0b",
                   $time, want.pos, want.segs, want.last,
                   digit_position_o, segment_bits_o, last_digit_o);
          fail_count++;
        end
      end
    end
  end

  int unsigned quiet_cycles;

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
      $display("calculator_lcd_segment_mapper_top_test NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_reset_state();
    // Display comes out of reset disabled, so everything must be dark.
    send_item(MODE_REFRESH, '1, '1);
  endtask

  task automatic test_segment_map();
    send_item(MODE_TOGGLE, '0, '0);
    send_item(MODE_REFRESH, '1, '0);
    send_item(MODE_REFRESH, '0, '1);
    send_item(MODE_REFRESH, '1, '1);
    send_item(MODE_REFRESH, {14{4'hA}}, {14{4'h5}});
    send_item(MODE_REFRESH, {14{4'h5}}, {14{4'hA}});
  endtask

  task automatic test_display_modes();
    send_item(MODE_OFF, '1, '1);
    send_item(MODE_REFRESH, '1, '1);
    send_item(MODE_TOGGLE, '0, '0);
    send_item(MODE_REFRESH, random_register(), random_register());
    send_item(MODE_TOGGLE, '0, '0);
    send_item(MODE_TOGGLE, '1, '1);
    send_item(MODE_REFRESH, '1, '1);
  endtask

  task automatic test_blink_timing();
    wait_idle();
    write_divisor(32'd2);
    send_item(MODE_BLINK, '0, '0);
    repeat (4) send_item(MODE_REFRESH, '1, '1);
    wait_idle();
    write_divisor(32'd1);
    send_item(MODE_BLINK, '0, '0);
    repeat (2) send_item(MODE_REFRESH, '1, '1);
    // A zero divisor leaves the counter at zero, so the next refresh wraps it.
    wait_idle();
    write_divisor(32'd0);
    send_item(MODE_BLINK, '1, '1);
    repeat (2) send_item(MODE_REFRESH, '1, '1);
  endtask

  task automatic test_register_port();
    logic [31:0] rdata;
    wait_idle();
    // Upper write bits fall outside the 16-bit register.
    write_divisor(32'hFFFF_0003);
    apb_access(1'b1, ADDR_UNMAPPED, 32'h0000_1234, rdata);
    check_divisor_readback();
    write_divisor(32'h0000_FFFF);
  endtask

  task automatic test_random_traffic();
    logic [15:0] phase_div [5];
    int          pick;
    mode_e       m;
    phase_div = '{16'd1, 16'hFFFF, 16'd0, 16'd3, 16'd2};
    phase_div[4] = 16'($urandom_range(2, 12));
    for (int p = 0; p < 5; p++) begin
      wait_idle();
      write_divisor({16'($urandom), phase_div[p]});
      for (int i = 0; i < 70; i++) begin
        if (p == 2 && i == 35) wait_idle();
        pick = $urandom_range(0, 99);
        m = (pick < 72) ? MODE_REFRESH : (pick < 82) ? MODE_TOGGLE :
            (pick < 92) ? MODE_BLINK : MODE_OFF;
        send_item(m, random_register(), random_register());
      end
    end
  endtask

  initial begin
    rst_ni                  <= 1'b0;
    push                    <= 1'b0;
    mode_i                  <= MODE_REFRESH;
    low_register_nibbles_i  <= '0;
    high_register_nibbles_i <= '0;
    psel                    <= 1'b0;
    penable                 <= 1'b0;
    pwrite                  <= 1'b0;
    paddr                   <= '0;
    pwdata                  <= '0;
    cycle_count              = 0;
    stall_style              = 0;
    stall_len                = 0;
    quiet_cycles             = 0;
    disp_on                  = 1'b0;
    blink_on                 = 1'b0;
    phase_on                 = 1'b0;
    countdown                = 16'd0;
    divisor                  = 16'd150;
    fail_count               = 0;
    refresh_count            = 0;
    op_count                 = 0;
    digits_checked           = 0;
    lit_digits               = 0;
    phase_flips              = 0;
    burst_left               = 0;
    push_held                = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_segment_map();
    test_display_modes();
    test_blink_timing();
    test_register_port();
    test_random_traffic();
    wait_idle();

    $display("Covered %0d refreshes and %0d display ops; %0d digits checked, %0d of them lit.",
             refresh_count, op_count, digits_checked, lit_digits);
    $display("Blink phase flipped %0d times across divisors 0, 1, 2, 3 and 65535.", phase_flips);
    if (fail_count == 0) begin
      $display("calculator_lcd_segment_mapper_top_test OK");
    end else begin
      $display("calculator_lcd_segment_mapper_top_test NOT OK");
    end
    $finish;
  end

endmodule
